// File: hdl/bwpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwpt_pkg: shared types and constants
// Types, codes and wait tables for the bus wait and prefetch timing block.
// ----------------------------------------------------------------------------
package bwpt_pkg;

	typedef struct packed {
		logic        cmd;
		logic [31:0] address;
		logic [1:0]  width_code;
		logic        is_sequential;
		logic        is_code_fetch;
		logic        thumb_mode;
	} in_item_t;

	typedef struct packed {
		logic [4:0] wait_cycles;
		logic [1:0] prefetch_outcome;
	} out_item_t;

	localparam logic [1:0] OUT_MISS    = 2'd0;
	localparam logic [1:0] OUT_HEAD    = 2'd1;
	localparam logic [1:0] OUT_FLIGHT  = 2'd2;
	localparam logic [1:0] OUT_NOT_BUF = 2'd3;

	localparam logic [2:0] REG_ROM0_FIRST = 3'd0;
	localparam logic [2:0] REG_ROM0_NEXT  = 3'd1;
	localparam logic [2:0] REG_ROM1_FIRST = 3'd2;
	localparam logic [2:0] REG_ROM1_NEXT  = 3'd3;
	localparam logic [2:0] REG_ROM2_FIRST = 3'd4;
	localparam logic [2:0] REG_ROM2_NEXT  = 3'd5;
	localparam logic [2:0] REG_BACKUP     = 3'd6;
	localparam logic [2:0] REG_PREFETCH   = 3'd7;

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // capture item, compute times
		logic decide;   // resolve hit/miss, apply stop/start
		logic step;     // one fill step of the buffer
		logic finish;   // close advance, load result
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic adv_done; // no more fill steps needed
	} dp_stat_t;

	function automatic logic [3:0] first_wait(input logic [1:0] idx);
		case (idx)
			2'd0: first_wait = 4'd4;
			2'd1: first_wait = 4'd3;
			2'd2: first_wait = 4'd2;
			default: first_wait = 4'd8;
		endcase
	endfunction

	function automatic logic [2:0] base16(input logic [3:0] page);
		case (page)
			4'd2: base16 = 3'd3;
			default: base16 = 3'd1;
		endcase
	endfunction

	function automatic logic [2:0] base32(input logic [3:0] page);
		case (page)
			4'd2: base32 = 3'd6;
			4'd5, 4'd6: base32 = 3'd2;
			default: base32 = 3'd1;
		endcase
	endfunction

endpackage

// File: hdl/bwpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwpt_if: valid/ready channel
// Carries one beat of a payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface bwpt_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/bwpt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwpt_ctrl: sequencer
// Steps each item through load, decide, fill steps and finish.
// ----------------------------------------------------------------------------
module bwpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output bwpt_pkg::dp_cmd_t cmd,
	input  bwpt_pkg::dp_stat_t stat
);
	import bwpt_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_DECIDE, ST_STEP, ST_FINISH} state_t;
	state_t state_q;
	logic   out_valid_q;

	// Input taken in idle once the result slot is free or draining
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load   = in_valid && in_ready;
		cmd.decide = (state_q == ST_DECIDE);
		cmd.step   = (state_q == ST_STEP) && !stat.adv_done;
		cmd.finish = (state_q == ST_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid && in_ready) state_q <= ST_DECIDE;
				ST_DECIDE: state_q <= ST_STEP;
				ST_STEP: if (stat.adv_done) state_q <= ST_FINISH;
				ST_FINISH: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/bwpt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwpt_dp: timing datapath
// Wait registers, access time lookup and the prefetch buffer state.
// ----------------------------------------------------------------------------
module bwpt_dp #(
	parameter int THUMB_DEPTH = 8,
	parameter int ARM_DEPTH   = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [1:0]          cfg_data,
	input  bwpt_pkg::in_item_t  in_item,
	input  bwpt_pkg::dp_cmd_t   cmd,
	output bwpt_pkg::dp_stat_t  stat,
	output bwpt_pkg::out_item_t result
);
	import bwpt_pkg::*;

	// Configuration registers
	logic [1:0] first_q [3];
	logic [2:0] fast_q;
	logic [1:0] backup_q;
	logic       pf_on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q[0] <= '0; first_q[1] <= '0; first_q[2] <= '0;
			fast_q <= '0; backup_q <= '0; pf_on_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROM0_FIRST: first_q[0] <= cfg_data;
				REG_ROM0_NEXT:  fast_q[0]  <= cfg_data[0];
				REG_ROM1_FIRST: first_q[1] <= cfg_data;
				REG_ROM1_NEXT:  fast_q[1]  <= cfg_data[0];
				REG_ROM2_FIRST: first_q[2] <= cfg_data;
				REG_ROM2_NEXT:  fast_q[2]  <= cfg_data[0];
				REG_BACKUP:     backup_q   <= cfg_data;
				REG_PREFETCH:   pf_on_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Item decode (load cycle)
	logic [31:0] addr_a;
	logic [3:0]  page;
	logic        is_word, rom, seq_a;
	logic [1:0]  win;
	logic [4:0]  t16n, t16s;
	logic [5:0]  cyc_a, seq16_a, seq32_a;

	always_comb begin
		is_word = in_item.width_code[1];
		addr_a  = in_item.address;
		if (is_word) addr_a[1:0] = 2'b00;
		else if (in_item.width_code[0]) addr_a[0] = 1'b0;
		page = addr_a[27:24];
		rom  = page[3] && (page <= 4'd13);
		win  = 2'((page - 4'd8) >> 1);
		seq_a = in_item.is_sequential && !(rom && addr_a[16:0] == 17'd0);
		t16n = 5'd1 + {1'b0, first_wait(backup_q)};
		t16s = t16n;
		if (rom) begin
			t16n = 5'd1 + {1'b0, first_wait(first_q[win])};
			case (win)
				2'd0: t16s = fast_q[0] ? 5'd2 : 5'd3;
				2'd1: t16s = fast_q[1] ? 5'd2 : 5'd5;
				default: t16s = fast_q[2] ? 5'd2 : 5'd9;
			endcase
		end
		seq16_a = {1'b0, t16s};
		seq32_a = {t16s, 1'b0};
		if (page[3] && page != 4'd15) begin
			if (is_word) cyc_a = seq_a ? seq32_a : 6'({1'b0, t16n} + {1'b0, t16s});
			else cyc_a = seq_a ? seq16_a : {1'b0, t16n};
		end else begin
			cyc_a = is_word ? {3'b0, base32(page)} : {3'b0, base16(page)};
		end
	end

	// Captured item
	logic [31:0] addr_q;
	logic        cmd_q, rom_q, code_q, thumb_q;
	logic [5:0]  cyc_q, reload_new_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q       <= addr_a;
			cmd_q        <= in_item.cmd;
			rom_q        <= rom;
			code_q       <= in_item.is_code_fetch;
			thumb_q      <= in_item.thumb_mode;
			cyc_q        <= in_item.cmd ? 6'd1 : cyc_a;
			reload_new_q <= in_item.thumb_mode ? seq16_a : seq32_a;
		end
	end

	// Buffer state
	logic        act_q, bthumb_q;
	logic [31:0] head_q, tail_q;
	logic [3:0]  fill_q;
	logic [4:0]  left_q, reload_q;
	// Advance job
	logic [5:0]  adv_q;
	logic        adv_on_q, clr_after_q;
	logic [5:0]  wait_q;
	logic [1:0]  outc_q;

	logic [3:0] depth;
	assign depth = bthumb_q ? 4'(THUMB_DEPTH) : 4'(ARM_DEPTH);

	logic brk_q; // zero reload stops the fill loop after one fill

	logic can_fill, pen;
	assign can_fill = adv_on_q && act_q && !brk_q && fill_q < depth &&
		{1'b0, left_q} <= adv_q;
	assign stat.adv_done = !can_fill;
	assign pen = act_q && ((left_q == 5'd1) ||
		(!bthumb_q && left_q == (reload_q >> 1) + 5'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0; bthumb_q <= 1'b0; head_q <= '0; tail_q <= '0;
			fill_q <= '0; left_q <= '0; reload_q <= '0;
			adv_q <= '0; adv_on_q <= 1'b0; clr_after_q <= 1'b0;
			wait_q <= '0; outc_q <= OUT_NOT_BUF; brk_q <= 1'b0;
		end else if (cmd.decide) begin
			brk_q       <= 1'b0;
			clr_after_q <= 1'b0;
			outc_q      <= OUT_NOT_BUF;
			if (cmd_q || !rom_q) begin
				wait_q <= cyc_q; adv_q <= cyc_q; adv_on_q <= 1'b1;
			end else if (!code_q) begin
				wait_q <= cyc_q + {5'd0, pen}; adv_on_q <= 1'b0; act_q <= 1'b0;
			end else if (act_q && head_q == addr_q && fill_q != 4'd0) begin
				head_q <= head_q + (bthumb_q ? 32'd2 : 32'd4);
				fill_q <= fill_q - 4'd1;
				wait_q <= 6'd1; outc_q <= OUT_HEAD; adv_q <= 6'd1; adv_on_q <= 1'b1;
			end else if (act_q && tail_q == addr_q && left_q != 5'd0) begin
				wait_q <= {1'b0, left_q}; outc_q <= OUT_FLIGHT;
				adv_q <= {1'b0, left_q}; adv_on_q <= 1'b1; clr_after_q <= 1'b1;
			end else begin
				outc_q <= OUT_MISS; adv_on_q <= 1'b0;
				wait_q <= cyc_q + {5'd0, pen};
				act_q  <= 1'b0;
				if (pf_on_q) begin
					bthumb_q <= thumb_q;
					reload_q <= reload_new_q[4:0];
					left_q   <= reload_new_q[4:0];
					tail_q   <= addr_q + (thumb_q ? 32'd2 : 32'd4);
					head_q   <= addr_q + (thumb_q ? 32'd2 : 32'd4);
					fill_q   <= '0;
					act_q    <= 1'b1;
				end
			end
		end else if (cmd.step) begin
			adv_q  <= adv_q - {1'b0, left_q};
			tail_q <= tail_q + (bthumb_q ? 32'd2 : 32'd4);
			left_q <= reload_q;
			fill_q <= fill_q + 4'd1;
			if (reload_q == 5'd0) brk_q <= 1'b1;
		end else if (cmd.finish) begin
			if (adv_on_q && act_q && fill_q < depth)
				left_q <= 5'(left_q - adv_q[4:0]);
			if (clr_after_q) begin
				fill_q <= '0;
				head_q <= tail_q;
			end
			adv_on_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result.wait_cycles      <= (wait_q > 6'd31) ? 5'd31 : wait_q[4:0];
			result.prefetch_outcome <= outc_q;
		end
	end
endmodule

// File: hdl/bus_wait_and_prefetch_timing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_wait_and_prefetch_timing: bus wait and prefetch buffer timing
// Returns the wait cycles of each bus access or idle tick.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   cmd, address, width_code, is_sequential, is_code_fetch, thumb_mode
// out_ch   out  wait_cycles, prefetch_outcome
// cfg      in   cfg_we, cfg_index, cfg_data
// An item completes F buffer fills (at most the depth), one fill per cycle
// in the fill loop of the datapath.
// Reset clears configuration and buffer state; no clearing pass.
// A pending result holds in the output register until taken; the next item
// waits for that register to drain.
module bus_wait_and_prefetch_timing #(
	parameter int THUMB_DEPTH = 8,
	parameter int ARM_DEPTH   = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [1:0] cfg_data,
	bwpt_if.sink       in_ch,
	bwpt_if.source     out_ch
);
	import bwpt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bwpt_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd, .stat
	);

	bwpt_dp #(.THUMB_DEPTH(THUMB_DEPTH), .ARM_DEPTH(ARM_DEPTH)) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_item(in_ch.data), .cmd, .stat, .result(out_ch.data)
	);
endmodule
